// ----- design/md4_short_message_digest_macros.svh -----
// Assertion helpers shared by the digest block.
`ifndef MD4_SHORT_MESSAGE_DIGEST_MACROS_SVH
`define MD4_SHORT_MESSAGE_DIGEST_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MD4_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md4 digest: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MD4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md4 digest: next-cycle check failed");

`endif

// ----- design/md4_smd_pkg.sv -----
package md4_smd_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [31:0] K_R2 = 32'h5a827999;
    localparam logic [31:0] K_R3 = 32'h6ed9eba1;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam int NUM_STEPS = 48;
    localparam int NUM_WORDS = 8;
    localparam int LEN_WORD = 14;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t                a;
        word_t                b;
        word_t                c;
        word_t                d;
        logic [7:0][31:0]     m;
        logic [4:0]           len;
    } md4_state_t;

    localparam int WORD_ORDER [0:47] = '{
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
        0, 4, 8, 12, 1, 5, 9, 13, 2, 6, 10, 14, 3, 7, 11, 15,
        0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15
    };

    localparam int ROT_AMOUNT [0:11] = '{
        3, 7, 11, 19,
        3, 5, 9, 13,
        3, 9, 11, 15
    };

    function automatic int word_index(input int step);
        return WORD_ORDER[step];
    endfunction

    function automatic int rot_amount(input int step);
        return ROT_AMOUNT[(step / 16) * 4 + (step % 4)];
    endfunction

endpackage

// ----- design/md4_smd_if.sv -----
interface md4_smd_msg_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_words_0_1;
    logic [63:0] msg_words_2_3;
    logic [63:0] msg_words_4_5;
    logic [63:0] msg_words_6_7;
    logic [4:0]  msg_length;

    modport source (
        output valid, msg_words_0_1, msg_words_2_3, msg_words_4_5, msg_words_6_7,
               msg_length,
        input  ready
    );
    modport sink (
        input  valid, msg_words_0_1, msg_words_2_3, msg_words_4_5, msg_words_6_7,
               msg_length,
        output ready
    );
endinterface

interface md4_smd_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;

    modport source (
        output valid, digest_a, digest_b, digest_c, digest_d,
        input  ready
    );
    modport sink (
        input  valid, digest_a, digest_b, digest_c, digest_d,
        output ready
    );
endinterface

// ----- design/md4_smd_pad.sv -----
module md4_smd_pad
    import md4_smd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    md4_smd_msg_if.sink        msg,
    output logic               valid_out,
    input  logic               ready_dn,
    output md4_state_t         state_out
);

    logic             valid_reg;
    logic             valid_next;
    md4_state_t       state_reg;
    md4_state_t       state_next;
    logic [7:0][31:0] words;
    logic [2:0]       full;
    logic [1:0]       rem;
    word_t            keep;
    word_t            pad_word;

    assign msg.ready = !valid_reg || ready_dn;
    assign valid_next = msg.ready ? msg.valid : valid_reg;

    always_comb
    begin
        words = {msg.msg_words_6_7, msg.msg_words_4_5, msg.msg_words_2_3, msg.msg_words_0_1};
        full = msg.msg_length[4:2];
        rem = msg.msg_length[1:0];
        keep = (word_t'(1) << {rem, 3'b000}) - word_t'(1);
        pad_word = (words[full] & keep) | (word_t'(PAD_BYTE) << {rem, 3'b000});
        state_next.a = IV_A;
        state_next.b = IV_B;
        state_next.c = IV_C;
        state_next.d = IV_D;
        state_next.len = msg.msg_length;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            if (3'(i) < full)
            begin
                state_next.m[i] = words[i];
            end
            else if (3'(i) == full)
            begin
                state_next.m[i] = pad_word;
            end
            else
            begin
                state_next.m[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.ready && msg.valid)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// ----- design/md4_smd_cell.sv -----
module md4_smd_cell
    import md4_smd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid_in,
    output logic       ready_up,
    input  md4_state_t state_in,
    output logic       valid_out,
    input  logic       ready_dn,
    output md4_state_t state_out
);

    localparam int WIDX = word_index(STEP);
    localparam int ROT = rot_amount(STEP);
    localparam int ROUND = STEP / 16;
    localparam logic [2:0] WSEL = 3'(WIDX % NUM_WORDS);

    logic       valid_reg;
    md4_state_t state_reg;
    md4_state_t state_next;
    word_t      f;
    word_t      mw;
    word_t      sum;

    assign ready_up = !valid_reg || ready_dn;

    always_comb
    begin
        case (ROUND)
            0:       f = (state_in.b & state_in.c) | (~state_in.b & state_in.d);
            1:       f = ((state_in.b & state_in.c) | (state_in.b & state_in.d)
                         | (state_in.c & state_in.d)) + K_R2;
            default: f = (state_in.b ^ state_in.c ^ state_in.d) + K_R3;
        endcase
        if (WIDX < NUM_WORDS)
        begin
            mw = state_in.m[WSEL];
        end
        else if (WIDX == LEN_WORD)
        begin
            mw = {24'b0, state_in.len, 3'b000};
        end
        else
        begin
            mw = '0;
        end
        sum = state_in.a + f + mw;
        state_next = state_in;
        state_next.a = state_in.d;
        state_next.d = state_in.c;
        state_next.c = state_in.b;
        state_next.b = (sum << ROT) | (sum >> (32 - ROT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule

// ----- design/md4_smd_fin.sv -----
module md4_smd_fin
    import md4_smd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    output logic              ready_up,
    input  md4_state_t        state_in,
    md4_smd_digest_if.source  digest
);

    logic  valid_reg;
    word_t a_reg;
    word_t b_reg;
    word_t c_reg;
    word_t d_reg;

    assign ready_up = !valid_reg || digest.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_up)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_up && valid_in)
        begin
            a_reg <= state_in.a + IV_A;
            b_reg <= state_in.b + IV_B;
            c_reg <= state_in.c + IV_C;
            d_reg <= state_in.d + IV_D;
        end
    end

    assign digest.valid = valid_reg;
    assign digest.digest_a = a_reg;
    assign digest.digest_b = b_reg;
    assign digest.digest_c = c_reg;
    assign digest.digest_d = d_reg;

endmodule

// ----- design/md4_short_message_digest.sv -----
// MD4 digest of a message of 0 to 31 bytes, padded here into one block. A beat is
// taken every clock while any stage of the pipeline is free, so the sustained rate is
// one beat per cycle while the output takes each digest. Each beat passes through one
// padding stage, a chain of 48 step cells and one finishing stage. An output stall only
// backs up the stages that hold data, and empty stages keep absorbing new beats.
`include "md4_short_message_digest_macros.svh"

module md4_short_message_digest
    import md4_smd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    md4_smd_msg_if.sink      msg,
    md4_smd_digest_if.source digest
);

    logic       vld [0:NUM_STEPS];
    logic       rdy [0:NUM_STEPS];
    md4_state_t pipe [0:NUM_STEPS];

    md4_smd_pad u_pad (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .valid_out (vld[0]),
        .ready_dn  (rdy[0]),
        .state_out (pipe[0])
    );

    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_cell
        md4_smd_cell #(
            .STEP (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld[k]),
            .ready_up  (rdy[k]),
            .state_in  (pipe[k]),
            .valid_out (vld[k+1]),
            .ready_dn  (rdy[k+1]),
            .state_out (pipe[k+1])
        );
    end

    md4_smd_fin u_fin (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (vld[NUM_STEPS]),
        .ready_up (rdy[NUM_STEPS]),
        .state_in (pipe[NUM_STEPS]),
        .digest   (digest)
    );

    `MD4_ASSERT_NEXT(a_accept_fills_pad, msg.valid && msg.ready, vld[0])
    `MD4_ASSERT_SAME(a_empty_cell_ready, !vld[1], rdy[0])
    `MD4_ASSERT_NEXT(a_last_cell_moves, vld[NUM_STEPS] && rdy[NUM_STEPS], digest.valid)

endmodule
